// ===== rtl/bpn_pkg.sv =====
package bpn_pkg;

  localparam int ACTION_W   = 2;
  localparam int SIZE_W     = 19;
  localparam int OFF_W      = 18;
  localparam int STATUS_W   = 3;
  localparam int BS_W       = 13;
  localparam int TOTAL_W    = 19;
  localparam int MARK_W     = 19;
  localparam int DIVIDEND_W = 20;

  // quotient bits retired per divider cycle
  localparam int DIV_STEPS  = 2;

  localparam int NUM_BLOCKS_DEFAULT = 64;

  localparam logic [BS_W-1:0] BS_RESET = BS_W'(64);
  localparam logic [BS_W-1:0] BS_MIN   = BS_W'(1);
  localparam logic [BS_W-1:0] BS_MAX   = BS_W'(4096);

  localparam logic [ACTION_W-1:0] ACT_RESERVE = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_FREE    = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_CLEAR   = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK           = 3'd0;
  localparam logic [STATUS_W-1:0] ST_OOM          = 3'd1;
  localparam logic [STATUS_W-1:0] ST_BAD_ADDR     = 3'd2;
  localparam logic [STATUS_W-1:0] ST_ALREADY_FREE = 3'd3;
  localparam logic [STATUS_W-1:0] ST_BAD_SIZE     = 3'd4;

  typedef struct packed {
    logic                  start;
    logic [DIVIDEND_W-1:0] dividend;
    logic [BS_W-1:0]       divisor;
  } div_req_t;

  typedef struct packed {
    logic                  done;
    logic [DIVIDEND_W-1:0] quotient;
    logic [BS_W-1:0]       remainder;
  } div_rsp_t;

endpackage

// ===== rtl/bpn_ram.sv =====
module bpn_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/bpn_div.sv =====
module bpn_div import bpn_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  localparam int CYC   = DIVIDEND_W / DIV_STEPS;
  localparam int CNT_W = $clog2(CYC);

  logic                  busy;
  logic                  done;
  logic [CNT_W-1:0]      cnt;
  logic [BS_W-1:0]       part;
  logic [BS_W-1:0]       part_next;
  logic [DIVIDEND_W-1:0] quo;
  logic [DIVIDEND_W-1:0] quo_next;
  logic [BS_W-1:0]       dvs;
  logic [BS_W:0]         trial;

  // restoring division, DIV_STEPS quotient bits per cycle
  always_comb begin
    part_next = part;
    quo_next  = quo;
    trial     = '0;
    for (int k = 0; k < DIV_STEPS; k++) begin
      trial = {part_next, quo_next[DIVIDEND_W-1]};
      if (trial >= {1'b0, dvs}) begin
        part_next = BS_W'(trial - {1'b0, dvs});
        quo_next  = {quo_next[DIVIDEND_W-2:0], 1'b1};
      end else begin
        part_next = trial[BS_W-1:0];
        quo_next  = {quo_next[DIVIDEND_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        if (cnt == CNT_W'(CYC - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt + CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      part <= '0;
      quo  <= req.dividend;
      dvs  <= req.divisor;
    end else if (busy) begin
      part <= part_next;
      quo  <= quo_next;
    end
  end

  assign rsp.done      = done;
  assign rsp.quotient  = quo;
  assign rsp.remainder = part;

endmodule

// ===== rtl/block_pool_next_fit_allocator_top.sv =====
// Reserve scans from the next-fit cursor, checking free blocks one by one and skipping
// used runs with the divider, then marks the chosen blocks. Free divides the offset by
// the block size, reads the mark and releases the blocks it covers.
// Throughput: one transaction at a time; the next is taken once the result is queued.
// Reset: synchronous; a clearing pass zeroes the mark memory, during which no
// transaction is accepted (configuration still is). Block size resets to 64.
module block_pool_next_fit_allocator_top import bpn_pkg::*; #(
  parameter int NUM_BLOCKS = NUM_BLOCKS_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [BS_W-1:0]     cfg_block_size,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [ACTION_W-1:0] action,
  input  logic [SIZE_W-1:0]   request_size,
  input  logic [OFF_W-1:0]    byte_offset,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [STATUS_W-1:0] status,
  output logic [OFF_W-1:0]    region_offset,
  output logic [TOTAL_W-1:0]  bytes_in_use
);

  localparam int IDX_W  = $clog2(NUM_BLOCKS);
  localparam int J_W    = $clog2(NUM_BLOCKS + 1);
  localparam int CHK_W  = $clog2(2 * NUM_BLOCKS + 1);
  localparam int PROD_W = IDX_W + BS_W;

  localparam logic [3:0] S_CLR   = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_RLOOP = 4'd2;
  localparam logic [3:0] S_RCHK  = 4'd3;
  localparam logic [3:0] S_RTEST = 4'd4;
  localparam logic [3:0] S_RRUN  = 4'd5;
  localparam logic [3:0] S_RSKIP = 4'd6;
  localparam logic [3:0] S_MARK  = 4'd7;
  localparam logic [3:0] S_FDIV  = 4'd8;
  localparam logic [3:0] S_FISS  = 4'd9;
  localparam logic [3:0] S_FRD   = 4'd10;
  localparam logic [3:0] S_FCNT  = 4'd11;
  localparam logic [3:0] S_FCLR  = 4'd12;
  localparam logic [3:0] S_DONE  = 4'd13;

  logic [3:0]            state;
  logic                  clr_reply;
  logic [BS_W-1:0]       bs;
  logic [IDX_W-1:0]      cursor;
  logic [TOTAL_W-1:0]    total;
  logic [IDX_W-1:0]      pos;
  logic [CHK_W-1:0]      checked;
  logic [J_W-1:0]        idx;
  logic [J_W-1:0]        count;
  logic [DIVIDEND_W-1:0] avail;
  logic [SIZE_W-1:0]     size;
  logic [MARK_W-1:0]     rem;
  logic [STATUS_W-1:0]   res_status;
  logic [OFF_W-1:0]      res_region;

  logic                  mem_we;
  logic [MARK_W-1:0]     mem_wdata;
  logic [IDX_W-1:0]      mem_raddr;
  logic [MARK_W-1:0]     mem_rdata;
  div_req_t              div_req;
  div_rsp_t              div_rsp;

  logic                  in_fire;
  logic                  idx_in_pool;
  logic [J_W-1:0]        div_sat;
  logic [CHK_W-1:0]      skip_pos;
  logic [CHK_W-1:0]      scan_checked;
  logic                  scan_found;
  logic [IDX_W-1:0]      scan_pos;
  logic [PROD_W-1:0]     prod;
  logic [DIVIDEND_W-1:0] ceil_dividend;

  bpn_ram #(
    .WIDTH (MARK_W),
    .DEPTH (NUM_BLOCKS)
  ) u_marks (
    .clk   (clk),
    .we    (mem_we),
    .waddr (idx[IDX_W-1:0]),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  bpn_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == S_IDLE);
  assign in_fire   = in_valid && in_ready;

  assign idx_in_pool = (idx < J_W'(NUM_BLOCKS));
  assign div_sat     = (div_rsp.quotient >= DIVIDEND_W'(NUM_BLOCKS)) ?
                       J_W'(NUM_BLOCKS) : J_W'(div_rsp.quotient);
  assign skip_pos    = CHK_W'(pos) + CHK_W'(div_sat);

  // end of a free-run scan
  assign scan_checked = checked + CHK_W'(idx) - CHK_W'(pos);
  assign scan_found   = (avail >= DIVIDEND_W'(size));
  assign scan_pos     = idx_in_pool ? idx[IDX_W-1:0] : '0;

  assign prod = PROD_W'(pos) * PROD_W'(bs);

  // blocks covered by a mark: ceil(mark / block size)
  assign ceil_dividend = DIVIDEND_W'(mem_rdata) + DIVIDEND_W'(bs) - DIVIDEND_W'(1);

  assign mem_raddr = (state == S_RLOOP) ? pos : idx[IDX_W-1:0];
  assign mem_wdata = (state == S_MARK) ? rem : '0;

  always_comb begin
    mem_we = 1'b0;
    unique case (state)
      S_CLR:   mem_we = 1'b1;
      S_MARK:  mem_we = (rem != '0) && idx_in_pool;
      S_FCLR:  mem_we = (count != '0) && idx_in_pool;
      default: mem_we = 1'b0;
    endcase
  end

  always_comb begin
    div_req.divisor  = bs;
    div_req.start    = 1'b0;
    div_req.dividend = ceil_dividend;
    if (state == S_IDLE) begin
      div_req.start    = in_fire && (action == ACT_FREE);
      div_req.dividend = DIVIDEND_W'(byte_offset);
    end else if (state == S_RCHK) begin
      div_req.start = (mem_rdata != '0);
    end else if (state == S_FRD) begin
      div_req.start = (mem_rdata != '0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bs <= BS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_block_size == '0) begin
        bs <= BS_MIN;
      end else if (cfg_block_size > BS_MAX) begin
        bs <= BS_MAX;
      end else begin
        bs <= cfg_block_size;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLR;
      clr_reply <= 1'b0;
      idx       <= '0;
      cursor    <= '0;
      total     <= '0;
    end else begin
      unique case (state)
        S_CLR: begin
          if (idx == J_W'(NUM_BLOCKS - 1)) begin
            idx        <= '0;
            res_status <= ST_OK;
            state      <= clr_reply ? S_DONE : S_IDLE;
          end else begin
            idx <= idx + J_W'(1);
          end
        end
        S_IDLE: begin
          if (in_fire) begin
            size       <= request_size;
            res_region <= '0;
            res_status <= ST_OK;
            unique case (action)
              ACT_RESERVE: begin
                if (request_size == '0) begin
                  res_status <= ST_BAD_SIZE;
                  state      <= S_DONE;
                end else begin
                  pos     <= cursor;
                  checked <= '0;
                  state   <= S_RLOOP;
                end
              end
              ACT_FREE: state <= S_FDIV;
              ACT_CLEAR: begin
                cursor    <= '0;
                total     <= '0;
                idx       <= '0;
                clr_reply <= 1'b1;
                state     <= S_CLR;
              end
              default: state <= S_DONE;
            endcase
          end
        end
        S_RLOOP: begin
          if (checked >= CHK_W'(NUM_BLOCKS)) begin
            res_status <= ST_OOM;
            state      <= S_DONE;
          end else begin
            state <= S_RCHK;
          end
        end
        S_RCHK: begin
          if (mem_rdata != '0) begin
            state <= S_RSKIP;
          end else begin
            avail <= DIVIDEND_W'(bs);
            idx   <= J_W'(pos) + J_W'(1);
            state <= S_RTEST;
          end
        end
        S_RTEST: begin
          if ((avail < DIVIDEND_W'(size)) && idx_in_pool) begin
            state <= S_RRUN;
          end else if (scan_found) begin
            idx        <= J_W'(pos);
            rem        <= MARK_W'(size);
            res_region <= OFF_W'(prod);
            total      <= total + TOTAL_W'(size);
            state      <= S_MARK;
          end else begin
            checked <= scan_checked;
            pos     <= scan_pos;
            state   <= S_RLOOP;
          end
        end
        S_RRUN: begin
          if (mem_rdata == '0) begin
            avail <= avail + DIVIDEND_W'(bs);
            idx   <= idx + J_W'(1);
            state <= S_RTEST;
          end else begin
            // used block ends the run short of the request
            checked <= scan_checked;
            pos     <= scan_pos;
            state   <= S_RLOOP;
          end
        end
        S_RSKIP: begin
          if (div_rsp.done) begin
            checked <= checked + CHK_W'(div_sat);
            pos     <= (skip_pos >= CHK_W'(NUM_BLOCKS)) ? '0 : IDX_W'(skip_pos);
            state   <= S_RLOOP;
          end
        end
        S_MARK: begin
          if ((rem != '0) && idx_in_pool) begin
            rem <= (MARK_W'(bs) > rem) ? '0 : rem - MARK_W'(bs);
            idx <= idx + J_W'(1);
          end else begin
            cursor     <= idx_in_pool ? idx[IDX_W-1:0] : '0;
            res_status <= ST_OK;
            state      <= S_DONE;
          end
        end
        S_FDIV: begin
          if (div_rsp.done) begin
            if ((div_rsp.remainder != '0) ||
                (div_rsp.quotient >= DIVIDEND_W'(NUM_BLOCKS))) begin
              res_status <= ST_BAD_ADDR;
              state      <= S_DONE;
            end else begin
              idx   <= J_W'(div_rsp.quotient);
              state <= S_FISS;
            end
          end
        end
        S_FISS: state <= S_FRD;
        S_FRD: begin
          if (mem_rdata == '0) begin
            res_status <= ST_ALREADY_FREE;
            state      <= S_DONE;
          end else begin
            total <= (TOTAL_W'(mem_rdata) > total) ? '0 : total - TOTAL_W'(mem_rdata);
            state <= S_FCNT;
          end
        end
        S_FCNT: begin
          if (div_rsp.done) begin
            count <= div_sat;
            state <= S_FCLR;
          end
        end
        S_FCLR: begin
          if ((count != '0) && idx_in_pool) begin
            idx   <= idx + J_W'(1);
            count <= count - J_W'(1);
          end else begin
            res_status <= ST_OK;
            state      <= S_DONE;
          end
        end
        S_DONE: begin
          // hold until the output register is free
          if (!out_valid || out_ready) begin
            clr_reply <= 1'b0;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == S_DONE) && (!out_valid || out_ready)) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_DONE) && (!out_valid || out_ready)) begin
      status        <= res_status;
      region_offset <= res_region;
      bytes_in_use  <= total;
    end
  end

endmodule
